[hw/rtl/positional_list_store_top_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef POSITIONAL_LIST_STORE_TOP_MACROS_SVH
`define POSITIONAL_LIST_STORE_TOP_MACROS_SVH

// Implication checked on every rising clk edge outside reset.
`define PLS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every rising clk edge outside reset.
`define PLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Invariant checked on every rising clk edge outside reset.
`define PLS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

[hw/rtl/pls_pkg.sv]
package pls_pkg;

  // list geometry
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int POS_W    = 16;
  localparam int WORD_W   = 32;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // command codes
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  // status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // what the row of cells does this cycle
  typedef enum logic [1:0] {
    SH_HOLD   = 2'd0,
    SH_INSERT = 2'd1,
    SH_DELETE = 2'd2
  } shift_op_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    shift_op_t op;
    idx_t      idx;
    word_t     word;
  } cell_ctrl_t;

endpackage

[hw/rtl/positional_list_store_top.sv]
// Channel | Ports                                          | Handshake
// input   | in_command, in_position, in_value              | start && !busy
// result  | out_status, out_read_value, out_count          | out_valid, one cycle
//
// One command per cycle: busy stays low, and the result word appears on the
// cycle after the command is taken.
// All 64 cells compare their index with the position and shift in the same
// cycle; the read word comes from a one-hot OR over the row.
// Synchronous active-low reset empties the list; cell contents are not reset.
// The receiver cannot stall: each result is held for exactly one cycle.
`include "positional_list_store_top_macros.svh"

module positional_list_store_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_position,
  input  logic [31:0] in_value,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_read_value,
  output logic [6:0]  out_count
);

  localparam int N = pls_pkg::CAPACITY;

  logic                       accept;
  pls_pkg::cmd_t              cmd;
  logic [pls_pkg::CNT_W-1:0]  used_r;
  logic [pls_pkg::CNT_W-1:0]  used_nxt;
  logic                       out_valid_r;
  pls_pkg::status_t           status_r;
  pls_pkg::status_t           status_nxt;
  pls_pkg::word_t             rv_r;
  pls_pkg::word_t             rv_nxt;
  logic                       pos_nz;
  logic                       ins_ok;
  logic                       acc_ok;
  logic                       full;
  pls_pkg::cell_ctrl_t        ctrl;
  pls_pkg::word_t             words [N];
  pls_pkg::word_t             sel_words [N];
  pls_pkg::word_t             hit_word;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cmd    = pls_pkg::cmd_t'(in_command);

  // position range checks against the current length
  assign pos_nz = (in_position != '0);
  assign ins_ok = pos_nz && ({1'b0, in_position} <= (17'(used_r) + 17'd1));
  assign acc_ok = pos_nz && (in_position <= 16'(used_r));
  assign full   = (used_r == pls_pkg::CNT_W'(N));

  // decode the command into a row operation and the result word
  always_comb begin
    ctrl.op    = pls_pkg::SH_HOLD;
    ctrl.idx   = pls_pkg::IDX_W'(in_position - 16'd1);
    ctrl.word  = in_value;
    used_nxt   = used_r;
    status_nxt = pls_pkg::ST_DONE;
    rv_nxt     = '0;
    if (accept) begin
      unique case (cmd)
        pls_pkg::CMD_CLEAR: begin
          used_nxt = '0;
        end
        pls_pkg::CMD_INSERT: begin
          if (!ins_ok) begin
            status_nxt = pls_pkg::ST_RANGE;
          end else if (full) begin
            status_nxt = pls_pkg::ST_FULL;
          end else begin
            ctrl.op  = pls_pkg::SH_INSERT;
            used_nxt = used_r + 7'd1;
          end
        end
        pls_pkg::CMD_DELETE: begin
          if (!acc_ok) begin
            status_nxt = pls_pkg::ST_RANGE;
          end else begin
            ctrl.op  = pls_pkg::SH_DELETE;
            rv_nxt   = hit_word;
            used_nxt = used_r - 7'd1;
          end
        end
        pls_pkg::CMD_READ: begin
          if (!acc_ok) begin
            status_nxt = pls_pkg::ST_RANGE;
          end else begin
            rv_nxt = hit_word;
          end
        end
        default: status_nxt = pls_pkg::ST_DONE;
      endcase
    end
  end

  // row of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    pls_pkg::word_t left_w;
    pls_pkg::word_t right_w;
    if (i == 0) begin : g_head
      assign left_w = words[i];
    end else begin : g_left
      assign left_w = words[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign right_w = words[i];
    end else begin : g_right
      assign right_w = words[i+1];
    end
    pls_cell u_cell (
      .clk        (clk),
      .cell_idx   (pls_pkg::IDX_W'(i)),
      .ctrl       (ctrl),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[i]),
      .sel_word   (sel_words[i])
    );
  end

  // one-hot read bus
  always_comb begin
    hit_word = '0;
    for (int j = 0; j < N; j++) begin
      hit_word = hit_word | sel_words[j];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      out_valid_r <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rv_r     <= rv_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_read_value = rv_r;
  assign out_count      = used_r;

  `PLS_ASSERT_NEXT(a_result_follows, accept, out_valid, "no result after command")
  `PLS_ASSERT_ALWAYS(a_count_bound, used_r <= pls_pkg::CNT_W'(N), "count past capacity")
  `PLS_ASSERT_IMPL(a_fail_zero, out_valid && out_status != pls_pkg::ST_DONE, out_read_value == '0, "failed command returned data")
  `PLS_ASSERT_IMPL(a_full_count, out_valid && out_status == pls_pkg::ST_FULL, out_count == pls_pkg::CNT_W'(N), "full status on non-full list")
  `PLS_ASSERT_NEXT(a_fail_keeps_count, accept && !(cmd == pls_pkg::CMD_CLEAR) && !(cmd == pls_pkg::CMD_INSERT && ins_ok && !full) && !(cmd == pls_pkg::CMD_DELETE && acc_ok), used_r == $past(used_r), "count moved on no-op")

endmodule

[hw/rtl/pls_cell.sv]
module pls_cell (
  input  logic               clk,
  input  pls_pkg::idx_t      cell_idx,
  input  pls_pkg::cell_ctrl_t ctrl,
  input  pls_pkg::word_t     left_word,
  input  pls_pkg::word_t     right_word,
  output pls_pkg::word_t     word,
  output pls_pkg::word_t     sel_word
);

  pls_pkg::word_t word_r;
  pls_pkg::word_t word_nxt;

  // shift toward the tail on insert, toward the head on delete
  always_comb begin
    word_nxt = word_r;
    unique case (ctrl.op)
      pls_pkg::SH_INSERT: begin
        if (cell_idx == ctrl.idx) begin
          word_nxt = ctrl.word;
        end else if (cell_idx > ctrl.idx) begin
          word_nxt = left_word;
        end
      end
      pls_pkg::SH_DELETE: begin
        if (cell_idx >= ctrl.idx) begin
          word_nxt = right_word;
        end
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

  // drive the read bus only when addressed
  assign sel_word = (cell_idx == ctrl.idx) ? word_r : '0;

endmodule
